// ===== src/btpc_pkg.sv =====
// shared types and constants for the barometric compensation block
package btpc_pkg;

	localparam int unsigned NumCfgRegs = 4;
	localparam int unsigned CfgIdxW    = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_WORD_A  = 2'd0,
		CFG_WORD_B  = 2'd1,
		CFG_WORD_C  = 2'd2,
		CFG_OVERSMP = 2'd3
	} cfg_idx_t;

	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	localparam logic signed [31:0] B6Offset  = 32'sd4000;
	localparam logic signed [31:0] B4Offset  = 32'sd32768;
	localparam logic [31:0]        B7Scale   = 32'd50000;
	localparam logic signed [31:0] PCoefSq   = 32'sd3038;
	localparam logic signed [31:0] PCoefLin  = -32'sd7357;
	localparam logic signed [31:0] PCoefOff  = 32'sd3791;
	localparam logic signed [31:0] TempMax   = 32'sd32767;
	localparam logic signed [31:0] TempMin   = -32'sd32768;
	localparam logic signed [31:0] PressMax  = 32'sd262143;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NOP      = 5'd0,
		OP_T_X1     = 5'd1,
		OP_T_DIV    = 5'd2,
		OP_T_DONE   = 5'd3,
		OP_P_B6     = 5'd4,
		OP_P_SQ     = 5'd5,
		OP_P_X1     = 5'd6,
		OP_P_X2     = 5'd7,
		OP_P_B3     = 5'd8,
		OP_P_X1B    = 5'd9,
		OP_P_X2B    = 5'd10,
		OP_P_B4     = 5'd11,
		OP_P_B7     = 5'd12,
		OP_P_DIV    = 5'd13,
		OP_P_Q      = 5'd14,
		OP_P_F1     = 5'd15,
		OP_P_F2     = 5'd16,
		OP_P_F3     = 5'd17,
		OP_P_DONE   = 5'd18
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_status_t;

endpackage

// ===== src/baro_temp_pressure_compensation.sv =====
// top level of the barometric temperature and pressure compensation block
// Usage: configure the four calibration registers through the cfg channel
// while idle (index 0..3, data in cfg_data). Then send items on in_valid /
// in_ready with action (0 temperature, 1 pressure) and raw_sample.
// Each item gives one result on out_valid / out_ready carrying result_kind,
// temperature_tenths, pressure_pa and divide_fault.
// The steps share one 32x32 multiplier, used at most once per step, and a
// serial divider that produces one quotient bit per cycle. A zero divisor
// skips the divider.
// One item is processed at a time; the next is accepted the cycle after the
// result has been taken. When the receiver stalls the result holds steady
// and no new item is taken.
// Reset clears the calibration registers and the stored b5 to zero, so a
// pressure item before any temperature item uses b5 of zero.
module baro_temp_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [18:0] raw_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic signed [15:0] temperature_tenths,
	output logic [17:0] pressure_pa,
	output logic        divide_fault
);
	import btpc_pkg::*;

	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	dp_cmd_t     cmd;
	dp_status_t  status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= 64'd0;
			cal_b_q <= 64'd0;
			cal_c_q <= 32'd0;
			oss_q   <= 2'd0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WORD_A:  cal_a_q <= cfg_data;
				CFG_WORD_B:  cal_b_q <= cfg_data;
				CFG_WORD_C:  cal_c_q <= cfg_data[31:0];
				CFG_OVERSMP: oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	btpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (result_kind),
		.cmd       (cmd),
		.status    (status)
	);

	btpc_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cal_a              (cal_a_q),
		.cal_b              (cal_b_q),
		.cal_c              (cal_c_q),
		.oss                (oss_q),
		.raw_in             (raw_sample),
		.temperature_tenths (temperature_tenths),
		.pressure_pa        (pressure_pa),
		.divide_fault       (divide_fault)
	);
endmodule

// ===== src/btpc_div.sv =====
// unsigned 33-bit by 32-bit restoring divider, one quotient bit per cycle
module btpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [32:0] quotient
);
	logic [32:0] quot_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic [33:0] trial;

	assign trial    = {rem_q[32:0], quot_q[32]} - {2'b00, dsr_q};
	assign busy     = (cnt_q != 6'd0);
	assign quotient = quot_q;

	// shift one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd33;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= 33'd0;
			dsr_q  <= divisor;
		end else if (busy) begin
			if (!trial[33]) begin
				rem_q  <= trial[32:0];
				quot_q <= {quot_q[31:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[31:0], quot_q[32]};
				quot_q <= {quot_q[31:0], 1'b0};
			end
		end
	end
endmodule

// ===== src/btpc_datapath.sv =====
// compensation datapath: one shared multiplier, shifter and the serial divider
module btpc_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  btpc_pkg::dp_cmd_t      cmd,
	output btpc_pkg::dp_status_t   status,
	input  logic [63:0]            cal_a,
	input  logic [63:0]            cal_b,
	input  logic [31:0]            cal_c,
	input  logic [1:0]             oss,
	input  logic [18:0]            raw_in,
	output logic signed [15:0]     temperature_tenths,
	output logic [17:0]            pressure_pa,
	output logic                   divide_fault
);
	import btpc_pkg::*;

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
	logic signed [31:0] raw_q, b5_q, b6_q, sq_q, x1_q, x2_q, acc_q, b3_q, p_q;
	logic [31:0]        b4_q, b7_q;
	logic               fault_q, neg_q;
	logic signed [15:0] tenths_q;
	logic [17:0]        pa_q;

	// operand select for the shared multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic [31:0]        pw;

	logic               div_start, div_busy;
	logic [32:0]        div_dividend, div_q;
	logic [31:0]        div_divisor;
	logic [31:0]        t_num_abs, t_den_abs, t_sum, p_sum, x3v;
	logic signed [31:0] p8;

	assign ac1 = 32'(signed'(cal_a[63:48]));
	assign ac2 = 32'(signed'(cal_a[47:32]));
	assign ac3 = 32'(signed'(cal_a[31:16]));
	assign ac4 = {16'd0, cal_a[15:0]};
	assign ac5 = {16'd0, cal_b[63:48]};
	assign ac6 = {16'd0, cal_b[47:32]};
	assign b1  = 32'(signed'(cal_b[31:16]));
	assign b2  = 32'(signed'(cal_b[15:0]));
	assign mc  = 32'(signed'(cal_c[31:16]));
	assign md  = 32'(signed'(cal_c[15:0]));
	assign p8  = p_q >>> 8;

	always_comb begin
		ma = 32'sd0;
		mb = 32'sd0;
		case (cmd.op)
			OP_T_X1:  begin ma = raw_q - ac6; mb = ac5; end
			OP_P_SQ:  begin ma = b6_q;        mb = b6_q; end
			OP_P_X1:  begin ma = b2;          mb = sq_q; end
			OP_P_X2:  begin ma = ac2;         mb = b6_q; end
			OP_P_X1B: begin ma = ac3;         mb = b6_q; end
			OP_P_X2B: begin ma = b1;          mb = sq_q; end
			OP_P_B4:  begin ma = ac4;         mb = x3v + B4Offset; end
			OP_P_B7:  begin ma = raw_q - b3_q; mb = signed'(B7Scale >> oss); end
			OP_P_F1:  begin ma = p8;          mb = p8; end
			OP_P_F2:  begin ma = x1_q;        mb = PCoefSq; end
			OP_P_F3:  begin ma = PCoefLin;    mb = p_q; end
			default:  begin ma = 32'sd0;      mb = 32'sd0; end
		endcase
	end

	assign prod = ma * mb;
	assign pw   = prod[31:0];
	assign x3v  = 32'(($signed(x1_q + x2_q) + 32'sd2) >>> 2);

	// signed temperature division done as magnitudes, zero quotient on a zero divisor
	assign t_den_abs = (x1_q + md) < 0 ? 32'(-(x1_q + md)) : 32'(x1_q + md);
	assign t_num_abs = mc < 0 ? 32'(-(mc * 32'sd2048)) : 32'(mc * 32'sd2048);
	assign t_sum     = 32'(x1_q + 32'(fault_q ? 32'sd0 :
		(neg_q ? -signed'(div_q[31:0]) : signed'(div_q[31:0]))));
	assign p_sum     = 32'(acc_q + x1_q + PCoefOff);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = 33'd0;
		div_divisor  = 32'd0;
		case (cmd.op)
			OP_T_DIV: begin
				div_start    = (x1_q + md) != 0;
				div_dividend = {1'b0, t_num_abs};
				div_divisor  = t_den_abs;
			end
			OP_P_DIV: begin
				div_start    = b4_q != 32'd0;
				div_dividend = b7_q[31] ? {1'b0, b7_q} : {b7_q, 1'b0};
				div_divisor  = b4_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	btpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign status.div_busy = div_busy;

	// stored b5 survives between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q <= 32'sd0;
		end else if (cmd.op == OP_T_DONE) begin
			b5_q <= t_sum;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q   <= {13'd0, raw_in};
			fault_q <= 1'b0;
		end
		case (cmd.op)
			OP_T_X1: x1_q <= signed'(pw) >>> 15;
			OP_T_DIV: begin
				neg_q <= (mc < 0) != ((x1_q + md) < 0);
				if ((x1_q + md) == 0) fault_q <= 1'b1;
			end
			OP_T_DONE: begin
				if (signed'(t_sum + 32'sd8) >>> 4 > TempMax) tenths_q <= 16'sh7fff;
				else if (signed'(t_sum + 32'sd8) >>> 4 < TempMin) tenths_q <= -16'sh8000;
				else tenths_q <= 16'(signed'(t_sum + 32'sd8) >>> 4);
				pa_q <= 18'd0;
			end
			OP_P_B6:  b6_q <= b5_q - B6Offset;
			OP_P_SQ:  sq_q <= signed'(pw) >>> 12;
			OP_P_X1:  x1_q <= signed'(pw) >>> 11;
			OP_P_X2:  x2_q <= signed'(pw) >>> 11;
			OP_P_B3:  b3_q <= signed'(((ac1 <<< 2) + x1_q + x2_q) <<< oss) + 32'sd2 >>> 2;
			OP_P_X1B: x1_q <= signed'(pw) >>> 13;
			OP_P_X2B: x2_q <= signed'(pw) >>> 16;
			OP_P_B4:  b4_q <= pw >> 15;
			OP_P_B7:  b7_q <= pw;
			OP_P_DIV: if (b4_q == 32'd0) fault_q <= 1'b1;
			// a top-half b7 was divided undoubled, so double the quotient here
			OP_P_Q:   p_q  <= fault_q ? 32'sd0 :
				(b7_q[31] ? signed'({div_q[30:0], 1'b0}) : signed'(div_q[31:0]));
			OP_P_F1:  x1_q <= signed'(pw);
			OP_P_F2:  acc_q <= signed'(pw) >>> 16;
			OP_P_F3:  x1_q <= signed'(pw) >>> 16;
			OP_P_DONE: begin
				if (signed'(p_q + (signed'(p_sum) >>> 4)) < 0) pa_q <= 18'd0;
				else if (signed'(p_q + (signed'(p_sum) >>> 4)) > PressMax) pa_q <= 18'h3ffff;
				else pa_q <= 18'(p_q + (signed'(p_sum) >>> 4));
				tenths_q <= 16'sd0;
			end
			default: ;
		endcase
	end

	assign temperature_tenths = tenths_q;
	assign pressure_pa        = pa_q;
	assign divide_fault       = fault_q;
endmodule

// ===== src/btpc_ctrl.sv =====
// sequencer for the compensation datapath and the item handshake
module btpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kind,
	output btpc_pkg::dp_cmd_t    cmd,
	input  btpc_pkg::dp_status_t status
);
	import btpc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   kind_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign kind      = kind_q;
	assign cmd.load  = in_valid && in_ready;
	assign cmd.op    = (state_q == ST_RUN) ? op_q : OP_NOP;

	// step through the micro-operation list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NOP;
			kind_q  <= KIND_TEMP;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					kind_q  <= action;
					op_q    <= action ? OP_P_B6 : OP_T_X1;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					case (op_q)
						OP_T_DIV, OP_P_DIV: begin
							op_q <= op_t'(op_q + 5'd1);
							state_q <= ST_WAIT;
						end
						OP_T_DONE, OP_P_DONE: state_q <= ST_OUT;
						default: op_q <= op_t'(op_q + 5'd1);
					endcase
				end
				ST_WAIT: if (!status.div_busy) state_q <= ST_RUN;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== src/btpc_checker.sv =====
// port-level checks for the compensation block
module btpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic [17:0] pressure_pa,
	input logic signed [15:0] temperature_tenths
);
	// one item at a time: no input taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// a taken item closes the input: it is not open right after the take
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input open right after item");
	// a taken result is not shown again next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result repeated");
	// temperature result reports no pressure
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == 1'b0 |-> pressure_pa == 18'd0)
		else $error("pressure on temperature result");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pa)
		&& $stable(temperature_tenths)) else $error("result changed under stall");
endmodule

bind baro_temp_pressure_compensation btpc_checker u_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.result_kind        (result_kind),
	.pressure_pa        (pressure_pa),
	.temperature_tenths (temperature_tenths)
);
